// ===== sv/daf_pkg.sv =====
// ----------------------------------------------------------------------------
// daf_pkg: shared types and constants of the decimal ASCII field formatter
// Holds the transaction structs, the layout codes, the per-stage sideband
// and the divide-by-ten constants used by the digit pipeline.
// ----------------------------------------------------------------------------
package daf_pkg;

  // Width of the signed input value
  localparam int unsigned VALUE_WIDTH = 28;
  localparam int unsigned LAYOUT_WIDTH = 5;
  // Number of decimal digits extracted from the magnitude
  localparam int unsigned NUM_DIGITS = 7;
  // Number of magnitude thresholds (>= 10, 100, 1000, 10000)
  localparam int unsigned NUM_THRESH = 4;

  // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [LAYOUT_WIDTH-1:0] {
    LAY_INT3          = 5'd0,
    LAY_INT4_SIGN     = 5'd1,
    LAY_UINT2         = 5'd2,
    LAY_TENTHS_S4     = 5'd3,
    LAY_TENTHS_U4     = 5'd4,
    LAY_HUND_S3       = 5'd5,
    LAY_THOU_S1       = 5'd6,
    LAY_HUND_U1       = 5'd7,
    LAY_SPACED        = 5'd8,
    LAY_INT_DOT0      = 5'd9,
    LAY_INT3_ALT      = 5'd10,
    LAY_UINT_LEFT     = 5'd11,
    LAY_UINT4         = 5'd12,
    LAY_INT4_SIGN_ALT = 5'd13,
    LAY_UINT5         = 5'd14,
    LAY_TENTHS_S5     = 5'd15,
    LAY_HUND_S5       = 5'd16
  } layout_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [LAYOUT_WIDTH-1:0]       layout;
  } in_t;

  typedef struct packed {
    logic [7:0] char_0;
    logic [7:0] char_1;
    logic [7:0] char_2;
    logic [7:0] char_3;
    logic [7:0] char_4;
    logic [7:0] char_5;
    logic [7:0] char_6;
    logic [2:0] field_length;
  } out_t;

  // Sideband carried down the digit pipeline
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] dig;
    logic [NUM_THRESH-1:0]      nz;
    logic                       neg;
    logic [LAYOUT_WIDTH-1:0]    layout;
  } meta_t;

  // ASCII digit from a BCD digit
  function automatic logic [7:0] dchar(logic [3:0] d);
    return CH_ZERO | {4'b0000, d};
  endfunction

endpackage

// ===== sv/daf_div10_stage.sv =====
// ----------------------------------------------------------------------------
// daf_div10_stage: one divide-by-ten step of the digit pipeline
// Divides the running quotient by ten with a reciprocal multiply, records
// the remainder as digit Idx and flags a nonzero quotient as a threshold.
// ----------------------------------------------------------------------------
module daf_div10_stage #(
  parameter int unsigned Idx = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [daf_pkg::VALUE_WIDTH-1:0]     in_q_i,
  input  daf_pkg::meta_t                      in_meta_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [daf_pkg::VALUE_WIDTH-1:0]     out_q_o,
  output daf_pkg::meta_t                      out_meta_o
);

  logic [63:0]                        prod;
  logic [daf_pkg::VALUE_WIDTH-1:0]    quot;
  logic [7:0]                         tens;
  logic [3:0]                         digit;
  daf_pkg::meta_t                     meta_d, meta_q;
  logic [daf_pkg::VALUE_WIDTH-1:0]    q_q;
  logic                               valid_q;
  logic                               load;

  // Divide by ten and recover the remainder from the low bits
  always_comb begin
    prod  = 64'({{(32 - daf_pkg::VALUE_WIDTH){1'b0}}, in_q_i})
          * 64'(daf_pkg::DIV10_MAGIC);
    quot  = daf_pkg::VALUE_WIDTH'(prod >> daf_pkg::DIV10_SHIFT);
    tens  = 8'(quot[3:0]) * 8'd10;
    digit = in_q_i[3:0] - tens[3:0];
    meta_d          = in_meta_i;
    meta_d.dig[Idx] = digit;
    meta_d.nz       = in_meta_i.nz
                    | (daf_pkg::NUM_THRESH'(|quot) << Idx);
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Hold the stage valid until the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      q_q    <= quot;
      meta_q <= meta_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_q_o     = q_q;
  assign out_meta_o  = meta_q;

endmodule

// ===== sv/daf_format.sv =====
// ----------------------------------------------------------------------------
// daf_format: layout selection of the decimal ASCII field formatter
// Builds the ASCII characters and field length from the extracted digits,
// the magnitude thresholds and the sign.
// ----------------------------------------------------------------------------
module daf_format (
  input  daf_pkg::meta_t meta_i,
  output daf_pkg::out_t  data_o
);

  logic [daf_pkg::NUM_DIGITS-1:0][7:0] c;
  logic [daf_pkg::NUM_DIGITS-1:0][7:0] d;
  logic [2:0]                          len;
  logic [7:0]                          sgn;
  logic [7:0]                          sgn_blank;
  logic                                ge10, ge100, ge1000, ge10000;

  always_comb begin
    for (int i = 0; i < daf_pkg::NUM_DIGITS; i++) begin
      d[i] = daf_pkg::dchar(meta_i.dig[i]);
    end
    ge10      = meta_i.nz[0];
    ge100     = meta_i.nz[1];
    ge1000    = meta_i.nz[2];
    ge10000   = meta_i.nz[3];
    sgn       = meta_i.neg ? daf_pkg::CH_MINUS : daf_pkg::CH_PLUS;
    sgn_blank = meta_i.neg ? daf_pkg::CH_MINUS : daf_pkg::CH_SPACE;
    c   = '0;
    len = 3'd0;

    // Select characters per layout; positions past the length stay zero
    case (daf_pkg::layout_e'(meta_i.layout))
      daf_pkg::LAY_INT3, daf_pkg::LAY_INT3_ALT: begin
        c[0] = meta_i.neg ? daf_pkg::CH_MINUS : (ge100 ? d[2] : daf_pkg::CH_SPACE);
        c[1] = ge10 ? d[1] : daf_pkg::CH_SPACE;
        c[2] = d[0];
        len  = 3'd3;
      end
      daf_pkg::LAY_INT4_SIGN, daf_pkg::LAY_INT4_SIGN_ALT: begin
        if (ge100) begin
          c[0] = sgn_blank; c[1] = d[2]; c[2] = d[1];
        end else if (ge10) begin
          c[0] = daf_pkg::CH_SPACE; c[1] = sgn_blank; c[2] = d[1];
        end else begin
          c[0] = daf_pkg::CH_SPACE; c[1] = daf_pkg::CH_SPACE; c[2] = sgn_blank;
        end
        c[3] = d[0];
        len  = 3'd4;
      end
      daf_pkg::LAY_UINT2: begin
        c[0] = d[1]; c[1] = d[0];
        len  = 3'd2;
      end
      daf_pkg::LAY_TENTHS_S4: begin
        c[0] = sgn; c[1] = d[5]; c[2] = d[4]; c[3] = d[3];
        c[4] = daf_pkg::CH_POINT; c[5] = d[2];
        len  = 3'd6;
      end
      daf_pkg::LAY_TENTHS_U4: begin
        c[0] = d[5]; c[1] = d[4]; c[2] = d[3];
        c[3] = daf_pkg::CH_POINT; c[4] = d[2];
        len  = 3'd5;
      end
      daf_pkg::LAY_HUND_S3: begin
        c[0] = meta_i.neg ? daf_pkg::CH_MINUS : d[5];
        c[1] = d[4]; c[2] = d[3]; c[3] = daf_pkg::CH_POINT;
        c[4] = d[2]; c[5] = d[1];
        len  = 3'd6;
      end
      daf_pkg::LAY_THOU_S1: begin
        c[0] = meta_i.neg ? daf_pkg::CH_MINUS : d[3];
        c[1] = daf_pkg::CH_POINT; c[2] = d[2]; c[3] = d[1]; c[4] = d[0];
        len  = 3'd5;
      end
      daf_pkg::LAY_HUND_U1: begin
        c[0] = d[3]; c[1] = daf_pkg::CH_POINT; c[2] = d[2]; c[3] = d[1];
        len  = 3'd4;
      end
      daf_pkg::LAY_SPACED: begin
        // Blank leading zeros of the two high positions
        if (meta_i.neg) begin
          c[0] = daf_pkg::CH_MINUS;
          c[1] = (meta_i.dig[4] != 4'd0) ? d[4] : daf_pkg::CH_SPACE;
        end else if (meta_i.dig[5] != 4'd0) begin
          c[0] = d[5]; c[1] = d[4];
        end else begin
          c[0] = daf_pkg::CH_SPACE;
          c[1] = (meta_i.dig[4] != 4'd0) ? d[4] : daf_pkg::CH_SPACE;
        end
        c[2] = d[3];
        // Blank trailing zero decimals and an unneeded point
        if (meta_i.dig[1] != 4'd0) begin
          c[3] = daf_pkg::CH_POINT; c[4] = d[2]; c[5] = d[1];
        end else if (meta_i.dig[2] != 4'd0) begin
          c[3] = daf_pkg::CH_POINT; c[4] = d[2]; c[5] = daf_pkg::CH_SPACE;
        end else begin
          c[3] = daf_pkg::CH_SPACE; c[4] = daf_pkg::CH_SPACE;
          c[5] = daf_pkg::CH_SPACE;
        end
        len = 3'd6;
      end
      daf_pkg::LAY_INT_DOT0: begin
        c[0] = sgn; c[1] = d[2]; c[2] = d[1]; c[3] = d[0];
        c[4] = daf_pkg::CH_POINT; c[5] = daf_pkg::CH_ZERO;
        len  = 3'd6;
      end
      daf_pkg::LAY_UINT_LEFT: begin
        if (ge100) begin
          c[0] = d[2]; c[1] = d[1]; c[2] = d[0];
          len  = 3'd3;
        end else if (ge10) begin
          c[0] = d[1]; c[1] = d[0];
          len  = 3'd2;
        end else begin
          c[0] = d[0];
          len  = 3'd1;
        end
      end
      daf_pkg::LAY_UINT4: begin
        c[0] = ge1000 ? d[3] : daf_pkg::CH_SPACE;
        c[1] = ge100 ? d[2] : daf_pkg::CH_SPACE;
        c[2] = ge10 ? d[1] : daf_pkg::CH_SPACE;
        c[3] = d[0];
        len  = 3'd4;
      end
      daf_pkg::LAY_UINT5: begin
        c[0] = ge10000 ? d[4] : daf_pkg::CH_SPACE;
        c[1] = ge1000 ? d[3] : daf_pkg::CH_SPACE;
        c[2] = ge100 ? d[2] : daf_pkg::CH_SPACE;
        c[3] = ge10 ? d[1] : daf_pkg::CH_SPACE;
        c[4] = d[0];
        len  = 3'd5;
      end
      daf_pkg::LAY_TENTHS_S5: begin
        c[0] = sgn; c[1] = d[6]; c[2] = d[5]; c[3] = d[4]; c[4] = d[3];
        c[5] = daf_pkg::CH_POINT; c[6] = d[2];
        len  = 3'd7;
      end
      daf_pkg::LAY_HUND_S5: begin
        c[0] = sgn; c[1] = d[5]; c[2] = d[4]; c[3] = d[3];
        c[4] = daf_pkg::CH_POINT; c[5] = d[2]; c[6] = d[1];
        len  = 3'd7;
      end
      default: begin
        c   = '0;
        len = 3'd0;
      end
    endcase
  end

  assign data_o.char_0       = c[0];
  assign data_o.char_1       = c[1];
  assign data_o.char_2       = c[2];
  assign data_o.char_3       = c[3];
  assign data_o.char_4       = c[4];
  assign data_o.char_5       = c[5];
  assign data_o.char_6       = c[6];
  assign data_o.field_length = len;

endmodule

// ===== sv/decimal_ascii_field_formatter_top.sv =====
// ----------------------------------------------------------------------------
// decimal_ascii_field_formatter_top: signed value to fixed-width ASCII field
// Input register, a seven-stage divide-by-ten digit pipeline, layout
// selection and an output register, all under valid/ready flow control.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output side does not stall.
// Each passes through the input register, which loads at the accepting edge,
// then the seven divide-by-ten stages, one per decimal digit (each a 32-bit
// reciprocal multiply followed by a register), and the output register.
// A stall on the output backs up stage by stage; the input stays ready as
// long as any stage of the pipeline is empty.
module decimal_ascii_field_formatter_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  daf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output daf_pkg::out_t  out_data_o
);

  localparam int unsigned W = daf_pkg::VALUE_WIDTH;
  localparam int unsigned N = daf_pkg::NUM_DIGITS;

  logic [N:0]         pipe_valid;
  logic [N:0]         pipe_ready;
  logic [N:0][W-1:0]  pipe_q;
  daf_pkg::meta_t     pipe_meta [N+1];

  logic               neg;
  logic [W-1:0]       mag;
  daf_pkg::meta_t     meta_in;
  logic               in_valid_q;
  logic [W-1:0]       mag_q;
  daf_pkg::meta_t     meta_q;

  daf_pkg::out_t      fmt_data;
  logic               out_valid_q;
  daf_pkg::out_t      out_data_q;
  logic               last_ready;

  // Take the magnitude and sign of the incoming value
  always_comb begin
    neg            = in_data_i.value[W-1];
    mag            = neg ? W'(-in_data_i.value) : W'(in_data_i.value);
    meta_in        = '0;
    meta_in.neg    = neg;
    meta_in.layout = in_data_i.layout;
  end

  assign in_ready_o = !in_valid_q || pipe_ready[0];

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mag_q  <= mag;
      meta_q <= meta_in;
    end
  end

  assign pipe_valid[0] = in_valid_q;
  assign pipe_q[0]     = mag_q;
  assign pipe_meta[0]  = meta_q;

  // Digit pipeline: stage s yields decimal digit s of the magnitude
  for (genvar s = 0; s < N; s++) begin : g_digit
    daf_div10_stage #(
      .Idx (s)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (pipe_valid[s]),
      .in_ready_o  (pipe_ready[s]),
      .in_q_i      (pipe_q[s]),
      .in_meta_i   (pipe_meta[s]),
      .out_valid_o (pipe_valid[s+1]),
      .out_ready_i (pipe_ready[s+1]),
      .out_q_o     (pipe_q[s+1]),
      .out_meta_o  (pipe_meta[s+1])
    );
  end

  daf_format u_format (
    .meta_i (pipe_meta[N]),
    .data_o (fmt_data)
  );

  assign last_ready    = !out_valid_q || out_ready_i;
  assign pipe_ready[N] = last_ready;

  // Output register; hold the transaction until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_ready) begin
      out_valid_q <= pipe_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_ready && pipe_valid[N]) begin
      out_data_q <= fmt_data;
    end
  end

  // The final quotient is not needed past the last stage
  logic unused_q;
  assign unused_q = ^pipe_q[N];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/daf_checker.sv =====
// ----------------------------------------------------------------------------
// daf_checker: port-level checks of the decimal ASCII field formatter
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module daf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input daf_pkg::out_t out_data_o,
  input logic          out_valid_o,
  input logic          out_ready_i
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input backpressure only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side is free");

  // Drop the last character when the field is short
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_6 != 8'h00 |-> out_data_o.field_length == 3'd7)
    else $error("character beyond field length is not zero");

  // A zero-length field, from an undefined layout, has its first two characters zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.field_length == 3'd0 |->
      out_data_o.char_0 == 8'h00 && out_data_o.char_1 == 8'h00)
    else $error("error field carries characters");

endmodule

bind decimal_ascii_field_formatter_top daf_checker u_daf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking test of decimal_ascii_field_formatter_top
// Drives a directed table of values and layouts, then random bursts across
// all layouts (undefined codes included), and checks every output field
// against a behavioral predictor of the ASCII field or a hand-written field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_RANDOM = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int VW = daf_pkg::VALUE_WIDTH;
  localparam int LW = daf_pkg::LAYOUT_WIDTH;

  typedef struct {
    daf_pkg::in_t  stim;
    bit            has_fixed;
    daf_pkg::out_t fixed;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  daf_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  daf_pkg::out_t out_data_o;

  daf_pkg::out_t field_queue[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            fields_seen = 0;
  bit            hold_req = 1'b0;
  bit            hold_taken = 1'b0;
  bit            drained_once = 1'b0;
  row_t          directed_rows[$];

  decimal_ascii_field_formatter_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Digit of a magnitude at place value div, as ASCII
  function automatic logic [7:0] digit_char(longint unsigned m, longint unsigned div);
    return daf_pkg::CH_ZERO + 8'((m / div) % 10);
  endfunction

  // Predict the ASCII field for one value and layout
  function automatic daf_pkg::out_t format_field(daf_pkg::in_t t);
    logic [7:0] c[7];
    int len;
    bit neg;
    longint sv;
    longint unsigned m, q, d;
    logic [7:0] sgn;
    daf_pkg::out_t r;
    foreach (c[i]) c[i] = daf_pkg::CH_NUL;
    neg = t.value[VW-1];
    sv = longint'($signed(t.value));
    m = neg ? -sv : sv;
    sgn = neg ? daf_pkg::CH_MINUS : daf_pkg::CH_PLUS;
    len = 0;
    case (t.layout)
      daf_pkg::LAY_INT3, daf_pkg::LAY_INT3_ALT: begin
        c[0] = neg ? daf_pkg::CH_MINUS
                   : (m >= 100 ? digit_char(m, 100) : daf_pkg::CH_SPACE);
        c[1] = m >= 10 ? digit_char(m, 10) : daf_pkg::CH_SPACE;
        c[2] = digit_char(m, 1);
        len = 3;
      end
      daf_pkg::LAY_INT4_SIGN, daf_pkg::LAY_INT4_SIGN_ALT: begin
        if (m >= 100) begin
          c[0] = neg ? daf_pkg::CH_MINUS : daf_pkg::CH_SPACE;
          c[1] = digit_char(m, 100);
          c[2] = digit_char(m, 10);
        end else if (m >= 10) begin
          c[0] = daf_pkg::CH_SPACE;
          c[1] = neg ? daf_pkg::CH_MINUS : daf_pkg::CH_SPACE;
          c[2] = digit_char(m, 10);
        end else begin
          c[0] = daf_pkg::CH_SPACE;
          c[1] = daf_pkg::CH_SPACE;
          c[2] = neg ? daf_pkg::CH_MINUS : daf_pkg::CH_SPACE;
        end
        c[3] = digit_char(m, 1);
        len = 4;
      end
      daf_pkg::LAY_UINT2: begin
        c[0] = digit_char(m, 10); c[1] = digit_char(m, 1); len = 2;
      end
      daf_pkg::LAY_TENTHS_S4: begin
        q = m / 100;
        c[0] = sgn; c[1] = digit_char(q, 1000); c[2] = digit_char(q, 100);
        c[3] = digit_char(q, 10); c[4] = daf_pkg::CH_POINT; c[5] = digit_char(q, 1);
        len = 6;
      end
      daf_pkg::LAY_TENTHS_U4: begin
        q = m / 100;
        c[0] = digit_char(q, 1000); c[1] = digit_char(q, 100);
        c[2] = digit_char(q, 10); c[3] = daf_pkg::CH_POINT; c[4] = digit_char(q, 1);
        len = 5;
      end
      daf_pkg::LAY_HUND_S3: begin
        q = m / 10;
        c[0] = neg ? daf_pkg::CH_MINUS : digit_char(q, 10000);
        c[1] = digit_char(q, 1000); c[2] = digit_char(q, 100);
        c[3] = daf_pkg::CH_POINT;
        c[4] = digit_char(q, 10); c[5] = digit_char(q, 1);
        len = 6;
      end
      daf_pkg::LAY_THOU_S1: begin
        c[0] = neg ? daf_pkg::CH_MINUS : digit_char(m, 1000);
        c[1] = daf_pkg::CH_POINT; c[2] = digit_char(m, 100);
        c[3] = digit_char(m, 10); c[4] = digit_char(m, 1);
        len = 5;
      end
      daf_pkg::LAY_HUND_U1: begin
        q = m / 10;
        c[0] = digit_char(q, 100); c[1] = daf_pkg::CH_POINT;
        c[2] = digit_char(q, 10); c[3] = digit_char(q, 1);
        len = 4;
      end
      daf_pkg::LAY_SPACED: begin
        q = m / 10;
        if (neg) begin
          c[0] = daf_pkg::CH_MINUS;
          d = (q / 1000) % 10;
          c[1] = d != 0 ? digit_char(q, 1000) : daf_pkg::CH_SPACE;
        end else begin
          d = (q / 10000) % 10;
          if (d != 0) begin
            c[0] = digit_char(q, 10000);
            c[1] = digit_char(q, 1000);
          end else begin
            c[0] = daf_pkg::CH_SPACE;
            d = (q / 1000) % 10;
            c[1] = d != 0 ? digit_char(q, 1000) : daf_pkg::CH_SPACE;
          end
        end
        c[2] = digit_char(q, 100);
        if (q % 10 != 0) begin
          c[3] = daf_pkg::CH_POINT; c[4] = digit_char(q, 10);
          c[5] = digit_char(q, 1);
        end else begin
          if ((q / 10) % 10 != 0) begin
            c[3] = daf_pkg::CH_POINT; c[4] = digit_char(q, 10);
          end else begin
            c[3] = daf_pkg::CH_SPACE; c[4] = daf_pkg::CH_SPACE;
          end
          c[5] = daf_pkg::CH_SPACE;
        end
        len = 6;
      end
      daf_pkg::LAY_INT_DOT0: begin
        c[0] = sgn; c[1] = digit_char(m, 100); c[2] = digit_char(m, 10);
        c[3] = digit_char(m, 1); c[4] = daf_pkg::CH_POINT; c[5] = daf_pkg::CH_ZERO;
        len = 6;
      end
      daf_pkg::LAY_UINT_LEFT: begin
        if (m >= 100) begin
          c[0] = digit_char(m, 100); c[1] = digit_char(m, 10);
          c[2] = digit_char(m, 1); len = 3;
        end else if (m >= 10) begin
          c[0] = digit_char(m, 10); c[1] = digit_char(m, 1); len = 2;
        end else begin
          c[0] = digit_char(m, 1); len = 1;
        end
      end
      daf_pkg::LAY_UINT4: begin
        c[0] = m >= 1000 ? digit_char(m, 1000) : daf_pkg::CH_SPACE;
        c[1] = m >= 100 ? digit_char(m, 100) : daf_pkg::CH_SPACE;
        c[2] = m >= 10 ? digit_char(m, 10) : daf_pkg::CH_SPACE;
        c[3] = digit_char(m, 1);
        len = 4;
      end
      daf_pkg::LAY_UINT5: begin
        c[0] = m >= 10000 ? digit_char(m, 10000) : daf_pkg::CH_SPACE;
        c[1] = m >= 1000 ? digit_char(m, 1000) : daf_pkg::CH_SPACE;
        c[2] = m >= 100 ? digit_char(m, 100) : daf_pkg::CH_SPACE;
        c[3] = m >= 10 ? digit_char(m, 10) : daf_pkg::CH_SPACE;
        c[4] = digit_char(m, 1);
        len = 5;
      end
      daf_pkg::LAY_TENTHS_S5: begin
        q = m / 100;
        c[0] = sgn; c[1] = digit_char(q, 10000); c[2] = digit_char(q, 1000);
        c[3] = digit_char(q, 100); c[4] = digit_char(q, 10);
        c[5] = daf_pkg::CH_POINT; c[6] = digit_char(q, 1);
        len = 7;
      end
      daf_pkg::LAY_HUND_S5: begin
        q = m / 10;
        c[0] = sgn; c[1] = digit_char(q, 10000); c[2] = digit_char(q, 1000);
        c[3] = digit_char(q, 100); c[4] = daf_pkg::CH_POINT;
        c[5] = digit_char(q, 10); c[6] = digit_char(q, 1);
        len = 7;
      end
      default: len = 0;
    endcase
    r.char_0 = c[0]; r.char_1 = c[1]; r.char_2 = c[2]; r.char_3 = c[3];
    r.char_4 = c[4]; r.char_5 = c[5]; r.char_6 = c[6];
    r.field_length = 3'(len);
    return r;
  endfunction

  function automatic daf_pkg::in_t make_item(longint v, int lay);
    daf_pkg::in_t t;
    t.value = VW'(v);
    t.layout = LW'(lay);
    return t;
  endfunction

  // Add a row checked by the predictor
  function automatic void add_row(longint v, int lay);
    row_t r;
    r.stim = make_item(v, lay);
    r.has_fixed = 1'b0;
    r.fixed = '0;
    directed_rows.push_back(r);
  endfunction

  // Add a row whose field is written out by hand
  function automatic void add_fixed(longint v, int lay, daf_pkg::out_t f);
    row_t r;
    r.stim = make_item(v, lay);
    r.has_fixed = 1'b1;
    r.fixed = f;
    directed_rows.push_back(r);
  endfunction

  // Queue the expected field, offer one transaction and hold it until accepted
  task automatic send_item(daf_pkg::in_t t, daf_pkg::out_t want);
    field_queue.push_back(want);
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random value: mostly small magnitudes, sometimes full range
  function automatic longint rand_value();
    case ($urandom_range(0, 4))
      0: return longint'($urandom_range(0, 199999)) - 100000;
      1: return longint'($urandom_range(0, 1999)) - 1000;
      2: return longint'($urandom_range(0, 39)) - 20;
      default: return longint'($signed(VW'($urandom)));
    endcase
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_ascii_field_formatter_top test failed");
      $finish;
    end
  end

  // Stall the receiver on its own pattern, with one long counted hold-off
  initial begin
    int phase;
    int hold_left;
    phase = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (phase % 200 < 60) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted field with the oldest prediction
  always @(posedge clk_i) begin
    daf_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_queue.size() == 0) begin
        $error("unexpected field %h", out_data_o);
        error_count++;
      end else begin
        want = field_queue.pop_front();
        fields_seen++;
        if (out_data_o.char_0 !== want.char_0) begin
          $error("char_0 expected %h actual %h", want.char_0, out_data_o.char_0);
          error_count++;
        end
        if (out_data_o.char_1 !== want.char_1) begin
          $error("char_1 expected %h actual %h", want.char_1, out_data_o.char_1);
          error_count++;
        end
        if (out_data_o.char_2 !== want.char_2) begin
          $error("char_2 expected %h actual %h", want.char_2, out_data_o.char_2);
          error_count++;
        end
        if (out_data_o.char_3 !== want.char_3) begin
          $error("char_3 expected %h actual %h", want.char_3, out_data_o.char_3);
          error_count++;
        end
        if (out_data_o.char_4 !== want.char_4) begin
          $error("char_4 expected %h actual %h", want.char_4, out_data_o.char_4);
          error_count++;
        end
        if (out_data_o.char_5 !== want.char_5) begin
          $error("char_5 expected %h actual %h", want.char_5, out_data_o.char_5);
          error_count++;
        end
        if (out_data_o.char_6 !== want.char_6) begin
          $error("char_6 expected %h actual %h", want.char_6, out_data_o.char_6);
          error_count++;
        end
        if (out_data_o.field_length !== want.field_length) begin
          $error("field_length expected %0d actual %0d",
                 want.field_length, out_data_o.field_length);
          error_count++;
        end
      end
    end
  end

  // Main stimulus
  initial begin
    int burst;
    int n;
    daf_pkg::in_t t;
    daf_pkg::out_t want;
    longint vmax, vmin;
    vmax = (longint'(1) << (VW - 1)) - 1;
    vmin = -(longint'(1) << (VW - 1));

    // Directed table: hand-written rows first, then predictor rows
    add_fixed(0, daf_pkg::LAY_INT3, '{8'h20, 8'h20, 8'h30, 0, 0, 0, 0, 3'd3});
    add_fixed(-5, daf_pkg::LAY_INT4_SIGN, '{8'h20, 8'h20, 8'h2D, 8'h35, 0, 0, 0, 3'd4});
    add_fixed(7, daf_pkg::LAY_UINT_LEFT, '{8'h37, 0, 0, 0, 0, 0, 0, 3'd1});
    add_fixed(12345, 17, '{0, 0, 0, 0, 0, 0, 0, 3'd0});
    add_fixed(-1, 31, '{0, 0, 0, 0, 0, 0, 0, 3'd0});
    for (int l = 0; l <= 16; l++) add_row((l % 2) ? vmin : vmax, l);
    add_row(-1200, daf_pkg::LAY_SPACED);
    add_row(1230, daf_pkg::LAY_SPACED);
    add_row(99999, daf_pkg::LAY_SPACED);

    in_valid_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      t = directed_rows[i].stim;
      want = directed_rows[i].has_fixed ? directed_rows[i].fixed : format_field(t);
      send_item(t, want);
    end
    pause_sender(1);

    // Random bursts with gaps
    n = 0;
    while (n < NUM_RANDOM) begin
      burst = $urandom_range(1, 30);
      // Long receiver hold-off while the sender keeps offering
      if (n >= 300 && !hold_req) begin
        hold_req = 1'b1;
        burst = 40;
      end
      for (int b = 0; b < burst && n < NUM_RANDOM; b++) begin
        if ($urandom_range(0, 15) == 0) t = make_item(rand_value(), $urandom_range(17, 31));
        else t = make_item(rand_value(), $urandom_range(0, 16));
        send_item(t, format_field(t));
        n++;
      end
      if (n >= 600 && !drained_once) begin
        drained_once = 1'b1;
        pause_sender(1);
        // Wait for every outstanding field to drain
        while (field_queue.size() != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    in_valid_i <= 1'b0;

    while (field_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d fields over all 17 layouts plus undefined codes,",
             fields_seen);
    $display("with extreme values, bursts, gaps and a long output hold-off.");
    if (error_count == 0) begin
      $display("decimal_ascii_field_formatter_top test passed");
    end else begin
      $display("decimal_ascii_field_formatter_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/daf_pkg.sv
sv/daf_div10_stage.sv
sv/daf_format.sv
sv/decimal_ascii_field_formatter_top.sv
sv/daf_checker.sv
test/testbench.sv
